@@ src/sfmc_pkg.sv @@
// ----------------------------------------------------------------------------
// SBUS frame to motor commands: shared types and constants
// Item, result, configuration and queue entry types, codes and limits.
// ----------------------------------------------------------------------------
package sfmc_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int AGE_BITS    = 11;
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int RAW_BITS    = 11;
    localparam int PROD_W      = 26;

    localparam logic [7:0] START_MARK    = 8'h0F;
    localparam logic [7:0] END_MARK      = 8'h00;
    localparam logic [7:0] FLAG_LOST     = 8'h04;
    localparam logic [7:0] FLAG_FAILSAFE = 8'h08;
    localparam logic [CNT_W-1:0] FLAG_INDEX = CNT_W'(23);
    localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(FRAME_BYTES - 1);

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_IDLE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_BYTE  = 3'd1;
    localparam logic [2:0] OP_FRAME = 3'd2;
    localparam logic [2:0] OP_DROP  = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_GOOD  = 3'd1;
    localparam logic [2:0] ST_LOST  = 3'd2;
    localparam logic [2:0] ST_DELIM = 3'd3;
    localparam logic [2:0] ST_SHORT = 3'd4;

    localparam logic [2:0] CFG_CENTER   = 3'd0;
    localparam logic [2:0] CFG_MIN      = 3'd1;
    localparam logic [2:0] CFG_MAX      = 3'd2;
    localparam logic [2:0] CFG_DEADBAND = 3'd3;
    localparam logic [2:0] CFG_CMD_MAX  = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT  = 3'd5;
    localparam logic [2:0] CFG_SEL_A    = 3'd6;
    localparam logic [2:0] CFG_SEL_B    = 3'd7;

    localparam int CFG_W = 15;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic signed [15:0] motor_a_command;
        logic signed [15:0] motor_b_command;
        logic               commands_valid;
        logic [2:0]         frame_status;
    } t_result;

    typedef struct packed {
        logic [10:0] channel_center;
        logic [10:0] channel_min;
        logic [10:0] channel_max;
        logic [9:0]  deadband;
        logic [14:0] command_max;
        logic [9:0]  timeout_ticks;
        logic [3:0]  channel_a_select;
        logic [3:0]  channel_b_select;
    } t_cfg;

    typedef struct packed {
        logic [2:0]       op;
        logic [CNT_W-1:0] idx;
        logic [7:0]       data;
    } t_op;

endpackage

@@ src/sfmc_front.sv @@
// ----------------------------------------------------------------------------
// SBUS front end
// Counts frame bytes and turns each accepted word into a queued operation.
// ----------------------------------------------------------------------------
module sfmc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sfmc_pkg::t_item i_item,
    input  logic          i_q_full,
    output logic          o_enq,
    output sfmc_pkg::t_op o_op
);
    import sfmc_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign full  = i_q_full;
    assign o_enq = push && !i_q_full;

    always_comb begin
        n_count   = r_count;
        o_op.op   = OP_NONE;
        o_op.idx  = r_count;
        o_op.data = i_item.data_byte;
        unique case (i_item.cmd)
            CMD_BYTE: begin
                if (r_count == LAST_INDEX) begin
                    o_op.op = OP_FRAME;
                    n_count = '0;
                end else begin
                    o_op.op = OP_BYTE;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_IDLE: begin
                if (r_count != '0) begin
                    o_op.op = OP_DROP;
                    n_count = '0;
                end
            end
            CMD_TICK: o_op.op = OP_TICK;
            default:  o_op.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_enq) begin
            r_count <= n_count;
        end
    end

endmodule

@@ src/sfmc_queue.sv @@
// ----------------------------------------------------------------------------
// SBUS operation queue
// Short first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
module sfmc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enq,
    input  sfmc_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_deq,
    output logic          o_valid,
    output sfmc_pkg::t_op o_op
);
    import sfmc_pkg::*;

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_used;

    assign o_full  = (r_used == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_used != '0);
    assign o_op    = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_slot[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_used <= '0;
        end else begin
            if (i_enq) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_deq) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_used <= r_used + (QPTR_W+1)'(i_enq) - (QPTR_W+1)'(i_deq);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_enq |-> (!o_full || i_deq)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_deq |-> o_valid) else $error("queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

@@ src/sfmc_back.sv @@
// ----------------------------------------------------------------------------
// SBUS back end
// Stores frame bytes, checks frames, maps channels to commands, emits words.
// ----------------------------------------------------------------------------
module sfmc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfmc_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  sfmc_pkg::t_op   i_op,
    output logic            o_deq,
    output logic            empty,
    input  logic            pop,
    output sfmc_pkg::t_result o_result
);
    import sfmc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MAP  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [7:0] r_store [FRAME_BYTES];
    logic [7:0] r_rd_data;

    logic [2:0]          r_state,   n_state;
    logic signed [15:0]  r_val_a,   n_val_a;
    logic signed [15:0]  r_val_b,   n_val_b;
    logic                r_good,    n_good;
    logic [AGE_BITS-1:0] r_age,     n_age;
    logic                r_out_valid;
    t_result             r_out;
    logic [7:0]          r_start_byte;
    logic [7:0]          r_flag_byte;
    logic                r_ch,      n_ch;
    logic [1:0]          r_step,    n_step;
    logic [7:0]          r_byte0,   r_byte1,  r_byte2;
    logic [10:0]         r_mag,     n_mag;
    logic [10:0]         r_span,    n_span;
    logic                r_neg,     n_neg;
    logic [PROD_W-1:0]   r_prod,    n_prod;
    logic [10:0]         r_rem,     n_rem;
    logic [4:0]          r_div_cnt, n_div_cnt;
    logic signed [15:0]  r_tmp_a,   n_tmp_a;

    logic        out_free;
    logic        out_load;
    logic [2:0]  out_status;
    logic        wr_en;
    logic [3:0]  sel;
    logic [7:0]  bitpos;
    logic [CNT_W-1:0] rd_addr;
    logic [23:0] word;
    logic [10:0] raw;
    logic signed [11:0] off;
    logic [11:0] span_full;
    logic [11:0] div_sh;
    logic        div_ge;
    logic [14:0] q_clamped;
    logic signed [15:0] q_signed;
    logic        valid_now;

    assign out_free = !r_out_valid || pop;
    assign empty    = !r_out_valid;
    assign o_result = r_out;

    assign sel     = r_ch ? i_cfg.channel_b_select : i_cfg.channel_a_select;
    assign bitpos  = {4'd0, sel} * 8'd11;
    assign rd_addr = bitpos[7:3] + CNT_W'(r_step) + CNT_W'(1);
    assign wr_en   = o_deq && (i_op.op == OP_BYTE || i_op.op == OP_FRAME);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[i_op.idx] <= i_op.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[rd_addr];
    end

    assign word      = {r_byte2, r_byte1, r_byte0};
    assign raw       = RAW_BITS'(word >> bitpos[2:0]);
    assign off       = $signed({1'b0, raw}) - $signed({1'b0, i_cfg.channel_center});
    assign span_full = off[11] ? ({1'b0, i_cfg.channel_center} - {1'b0, i_cfg.channel_min})
                               : ({1'b0, i_cfg.channel_max} - {1'b0, i_cfg.channel_center});
    assign div_sh    = {r_rem, r_prod[PROD_W-1]};
    assign div_ge    = div_sh >= {1'b0, r_span};
    assign q_clamped = (r_prod > PROD_W'(i_cfg.command_max)) ? i_cfg.command_max
                                                             : r_prod[14:0];
    assign q_signed  = r_neg ? -$signed({1'b0, q_clamped}) : $signed({1'b0, q_clamped});

    always_comb begin
        n_state    = r_state;
        n_val_a    = r_val_a;
        n_val_b    = r_val_b;
        n_good     = r_good;
        n_age      = r_age;
        n_ch       = r_ch;
        n_step     = r_step;
        n_mag      = r_mag;
        n_span     = r_span;
        n_neg      = r_neg;
        n_prod     = r_prod;
        n_rem      = r_rem;
        n_div_cnt  = r_div_cnt;
        n_tmp_a    = r_tmp_a;
        o_deq      = 1'b0;
        out_load   = 1'b0;
        out_status = ST_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_deq = 1'b1;
                    priority case (i_op.op)
                        OP_FRAME: begin
                            if (r_start_byte != START_MARK || i_op.data != END_MARK) begin
                                out_load   = 1'b1;
                                out_status = ST_DELIM;
                            end else if ((r_flag_byte & (FLAG_LOST | FLAG_FAILSAFE)) != 8'd0)
                            begin
                                n_val_a    = '0;
                                n_val_b    = '0;
                                n_good     = 1'b0;
                                n_age      = '0;
                                out_load   = 1'b1;
                                out_status = ST_LOST;
                            end else begin
                                n_ch    = 1'b0;
                                n_step  = '0;
                                n_state = S_READ;
                            end
                        end
                        OP_DROP: begin
                            out_load   = 1'b1;
                            out_status = ST_SHORT;
                        end
                        OP_TICK: begin
                            if (r_age != '1) begin
                                n_age = r_age + AGE_BITS'(1);
                            end
                            out_load = 1'b1;
                        end
                        default: out_load = 1'b1;
                    endcase
                end
            end
            S_READ: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_neg = off[11];
                n_mag = off[11] ? 11'(-off) : 11'(off);
                n_span = span_full[10:0];
                if (off == '0 || n_mag < {1'b0, i_cfg.deadband}) begin
                    n_prod  = '0;
                    n_state = S_NEXT;
                end else if (span_full[11] || span_full == '0) begin
                    n_prod  = PROD_W'(i_cfg.command_max);
                    n_state = S_NEXT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod    = PROD_W'(r_mag * i_cfg.command_max);
                n_rem     = '0;
                n_div_cnt = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                n_rem     = div_ge ? 11'(div_sh - {1'b0, r_span}) : div_sh[10:0];
                n_prod    = {r_prod[PROD_W-2:0], div_ge};
                n_div_cnt = r_div_cnt + 5'd1;
                if (r_div_cnt == 5'(PROD_W - 1)) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!r_ch) begin
                    n_tmp_a = q_signed;
                    n_ch    = 1'b1;
                    n_step  = '0;
                    n_state = S_READ;
                end else begin
                    n_val_a = r_tmp_a;
                    n_val_b = q_signed;
                    n_good  = 1'b1;
                    n_age   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = ST_GOOD;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign valid_now = n_good && ({{(AGE_BITS > 10 ? 1 : 11 - AGE_BITS){1'b0}}, n_age}
                       <= {{(AGE_BITS > 10 ? AGE_BITS - 9 : 1){1'b0}}, i_cfg.timeout_ticks});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_val_a     <= '0;
            r_val_b     <= '0;
            r_good      <= 1'b0;
            r_age       <= '0;
            r_out_valid <= 1'b0;
            r_ch        <= 1'b0;
            r_step      <= '0;
            r_div_cnt   <= '0;
        end else begin
            r_state   <= n_state;
            r_val_a   <= n_val_a;
            r_val_b   <= n_val_b;
            r_good    <= n_good;
            r_age     <= n_age;
            r_ch      <= n_ch;
            r_step    <= n_step;
            r_div_cnt <= n_div_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_span  <= n_span;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_rem   <= n_rem;
        r_tmp_a <= n_tmp_a;
        if (wr_en && i_op.idx == '0) begin
            r_start_byte <= i_op.data;
        end
        if (wr_en && i_op.idx == FLAG_INDEX) begin
            r_flag_byte <= i_op.data;
        end
        if (r_state == S_READ && r_step == 2'd1) begin
            r_byte0 <= r_rd_data;
        end
        if (r_state == S_READ && r_step == 2'd2) begin
            r_byte1 <= r_rd_data;
        end
        if (r_state == S_READ && r_step == 2'd3) begin
            r_byte2 <= r_rd_data;
        end
        if (out_load) begin
            r_out.motor_a_command <= valid_now ? n_val_a : '0;
            r_out.motor_b_command <= valid_now ? n_val_b : '0;
            r_out.commands_valid  <= valid_now;
            r_out.frame_status    <= out_status;
        end
    end

    a_deq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_deq |-> (r_state == S_IDLE && i_q_valid)) else $error("dequeue outside idle");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free) else $error("pending word overwritten");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div_cnt < 5'(PROD_W)) else $error("divider overrun");
    a_good_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> (r_good && r_age == '0)) else $error("good word without frame");

endmodule

@@ src/sbus_frame_to_motor_commands_core.sv @@
// A received byte, idle event or tick is taken and queued (four deep); the back end
// retires one word per cycle while no result is pending unpopped, except the last
// byte of a good frame: per channel it reads the bytes, maps, then multiplies and
// runs a 26-step restoring divider unless the map settles the command. push is held
// off by full only while the queue is full, so bursts of bytes run at one per cycle.
// ----------------------------------------------------------------------------
// SBUS frame to motor commands core
// Collects SBUS frames and turns two selected channels into signed commands.
// ----------------------------------------------------------------------------
module sbus_frame_to_motor_commands_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  sfmc_pkg::t_item          i_item,
    output logic                     empty,
    input  logic                     pop,
    output sfmc_pkg::t_result        o_result,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [sfmc_pkg::CFG_W-1:0] i_cfg_data
);
    import sfmc_pkg::*;

    t_cfg r_cfg;
    t_op  front_op;
    t_op  queue_op;
    logic enq;
    logic deq;
    logic q_full;
    logic q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_center   <= 11'd992;
            r_cfg.channel_min      <= 11'd172;
            r_cfg.channel_max      <= 11'd1811;
            r_cfg.deadband         <= 10'd20;
            r_cfg.command_max      <= 15'd25000;
            r_cfg.timeout_ticks    <= 10'd50;
            r_cfg.channel_a_select <= 4'd0;
            r_cfg.channel_b_select <= 4'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER:   r_cfg.channel_center   <= i_cfg_data[10:0];
                CFG_MIN:      r_cfg.channel_min      <= i_cfg_data[10:0];
                CFG_MAX:      r_cfg.channel_max      <= i_cfg_data[10:0];
                CFG_DEADBAND: r_cfg.deadband         <= i_cfg_data[9:0];
                CFG_CMD_MAX:  r_cfg.command_max      <= i_cfg_data[14:0];
                CFG_TIMEOUT:  r_cfg.timeout_ticks    <= i_cfg_data[9:0];
                CFG_SEL_A:    r_cfg.channel_a_select <= i_cfg_data[3:0];
                CFG_SEL_B:    r_cfg.channel_b_select <= i_cfg_data[3:0];
                default:      r_cfg.channel_center   <= r_cfg.channel_center;
            endcase
        end
    end

    sfmc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_enq    (enq),
        .o_op     (front_op)
    );

    sfmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_deq   (deq),
        .o_valid (q_valid),
        .o_op    (queue_op)
    );

    sfmc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_op      (queue_op),
        .o_deq     (deq),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule
